@@ hw/rtl/sgr_pkg.sv @@
// shared types, widths and register codes for the stereo gain ramp
`default_nettype none

package sgr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 25;
  localparam int FRAC_W   = 24;
  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int PROD_W   = MAG_W + GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;

  localparam logic [GAIN_W-1:0] TARGET_RST = GAIN_W'(1677722);
  localparam logic [GAIN_W-1:0] STEP_RST   = GAIN_W'(1522);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_GAIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = CFG_IDX_W'(2);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       zero_gain;
    logic                       block_end;
  } sgr_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic [GAIN_W-1:0]          gain_now;
    logic                       block_end_out;
  } sgr_out_t;

  typedef struct packed {
    logic [GAIN_W-1:0] goal_gain;
    logic              mute;
    logic [GAIN_W-1:0] ramp_step;
  } sgr_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/sgr_stream_if.sv @@
// valid/ready stream channel carrying one payload item
`default_nettype none

interface sgr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sgr_cfg.sv @@
// configuration registers of the stereo gain ramp
`default_nettype none

module sgr_cfg
  import sgr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output sgr_cfg_t                   cfg
);

  sgr_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.goal_gain <= TARGET_RST;
      cfg_r.mute      <= 1'b0;
      cfg_r.ramp_step <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GOAL_GAIN: cfg_r.goal_gain <= cfg_data[GAIN_W-1:0];
        CFG_MUTE:      cfg_r.mute      <= cfg_data[0];
        CFG_RAMP_STEP: cfg_r.ramp_step <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ hw/rtl/sgr_ramp.sv @@
// running gain: clear, step toward target, clamp at target
`default_nettype none

module sgr_ramp
  import sgr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sgr_cfg_t          cfg,
  input  wire logic              advance,
  input  wire logic              zero_gain,
  output logic [GAIN_W-1:0]      gain
);

  logic [GAIN_W-1:0] running_gain_r;
  logic [GAIN_W-1:0] target;
  logic [GAIN_W-1:0] g_start;
  logic [GAIN_W-1:0] diff;

  always_comb begin
    if (cfg.mute) begin
      target = '0;
    end else if (cfg.goal_gain > GAIN_ONE) begin
      target = GAIN_ONE;
    end else begin
      target = cfg.goal_gain;
    end

    g_start = zero_gain ? '0 : running_gain_r;

    if (g_start < target) begin
      diff = target - g_start;
      gain = (cfg.ramp_step >= diff) ? target : g_start + cfg.ramp_step;
    end else begin
      diff = g_start - target;
      gain = (cfg.ramp_step >= diff) ? target : g_start - cfg.ramp_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_gain_r <= '0;
    end else if (advance) begin
      running_gain_r <= gain;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sgr_scale.sv @@
// one sample times Q1.24 gain, truncated toward zero
`default_nettype none

module sgr_scale
  import sgr_pkg::*;
(
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic [GAIN_W-1:0]          gain,
  output logic signed [SAMPLE_W-1:0]      scaled
);

  logic                  neg;
  logic [MAG_W-1:0]      ext;
  logic [MAG_W-1:0]      mag;
  logic [PROD_W-1:0]     prod;
  logic [SAMPLE_W-1:0]   q;

  always_comb begin
    neg    = sample[SAMPLE_W-1];
    ext    = {sample[SAMPLE_W-1], sample};
    mag    = neg ? (~ext + MAG_W'(1)) : ext;
    prod   = PROD_W'(mag) * PROD_W'(gain);
    q      = prod[FRAC_W +: SAMPLE_W];
    scaled = neg ? $signed(~q + SAMPLE_W'(1)) : $signed(q);
  end

endmodule

`default_nettype wire

@@ hw/rtl/stereo_gain_ramp.sv @@
// top level of the stereo gain ramp
// one stereo frame enters on in_s and one result item leaves on out_s; both
// channels use valid/ready and move an item when both are high.
// an accepted item first updates the running gain (optional clear, one ramp
// step toward the target, clamp at the target) and is stored with that gain in
// the input stage; the next stage multiplies both samples by the gain and
// loads the result register.
// the result register loads from the input stage when it is empty or being taken.
// throughput: one item per cycle while out_s is ready; the running gain update
// is the only dependence between items and closes within the accepting cycle.
// when out_s stalls, the result register holds and the input stage, if empty,
// still takes one more item, after which in_s.ready drops until the result moves.
// configuration: cfg_we writes register cfg_index (0 goal gain, 1 mute,
// 2 ramp step) with cfg_data; write only while no item is in flight.
// reset (rst_n low, synchronous) empties both stages, zeroes the running gain
// and loads the register defaults (target about 0.1, unmuted, step 1522).
`default_nettype none

module stereo_gain_ramp
  import sgr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  sgr_stream_if.sink                 in_s,
  sgr_stream_if.source               out_s,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  sgr_cfg_t cfg;

  logic                       in_acc;
  logic                       s1_adv;
  logic [GAIN_W-1:0]          gain_new;

  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  logic signed [SAMPLE_W-1:0] s1_left_r;
  logic signed [SAMPLE_W-1:0] s1_right_r;
  logic [GAIN_W-1:0]          s1_gain_r;
  logic                       s1_block_end_r;

  logic signed [SAMPLE_W-1:0] left_scaled;
  logic signed [SAMPLE_W-1:0] right_scaled;

  logic                       out_valid_r;
  sgr_out_t                   out_data_r;

  sgr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign s1_adv    = !out_valid_r || out_s.ready;
  assign in_s.ready = !s1_valid_r || s1_adv;
  assign in_acc    = in_s.valid && in_s.ready;

  sgr_ramp u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .advance   (in_acc),
    .zero_gain (in_s.data.zero_gain),
    .gain      (gain_new)
  );

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_left_r      <= in_s.data.left_in;
      s1_right_r     <= in_s.data.right_in;
      s1_gain_r      <= gain_new;
      s1_block_end_r <= in_s.data.block_end;
    end
  end

  sgr_scale u_scale_left (
    .sample (s1_left_r),
    .gain   (s1_gain_r),
    .scaled (left_scaled)
  );

  sgr_scale u_scale_right (
    .sample (s1_right_r),
    .gain   (s1_gain_r),
    .scaled (right_scaled)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r.left_out      <= left_scaled;
      out_data_r.right_out     <= right_scaled;
      out_data_r.gain_now      <= s1_gain_r;
      out_data_r.block_end_out <= s1_block_end_r;
    end
  end

  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_data_r;

`ifndef SYNTHESIS
  a_gain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.gain_now <= GAIN_ONE))
    else $error("gain above one on result item");

  a_zero_gain_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.gain_now == '0) |->
      (out_data_r.left_out == '0 && out_data_r.right_out == '0))
    else $error("nonzero sample with zero gain");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_gain_r)))
    else $error("input stage lost item while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for the stereo gain ramp: random frames, register sweeps, gain prediction
module tb_top
  import sgr_pkg::*;
();

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sgr_stream_if #(.payload_t(sgr_in_t)) in_ch ();
  sgr_stream_if #(.payload_t(sgr_out_t)) out_ch ();

  stereo_gain_ramp uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_s(in_ch.sink),
    .out_s(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  sgr_in_t pend_frames[$];
  sgr_out_t expected_frames[$];

  logic [GAIN_W-1:0] vol_cfg = TARGET_RST;
  logic mute_cfg = 1'b0;
  logic [GAIN_W-1:0] step_cfg = STEP_RST;
  logic [GAIN_W-1:0] gain_track = '0;

  int errors = 0;
  int idle_left = 0;
  int stall_left = 0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic signed [SAMPLE_W-1:0] scale_sample(
    input logic signed [SAMPLE_W-1:0] s, input logic [GAIN_W-1:0] g);
    logic [MAG_W-1:0] mag;
    logic [PROD_W-1:0] prod;
    logic [SAMPLE_W-1:0] q;
    mag = s[SAMPLE_W-1] ? (~{1'b1, s} + 1'b1) : {1'b0, s};
    prod = PROD_W'(mag) * PROD_W'(g);
    q = prod[FRAC_W+SAMPLE_W-1:FRAC_W];
    if (s[SAMPLE_W-1]) q = -q;
    return q;
  endfunction

  // clear, one ramp step toward the target with clamp, then scale both samples
  function automatic sgr_out_t ramp_and_scale(input sgr_in_t f);
    logic [GAIN_W-1:0] tgt;
    logic [GAIN_W-1:0] g;
    sgr_out_t r;
    if (f.zero_gain) gain_track = '0;
    tgt = mute_cfg ? '0 : ((vol_cfg > GAIN_ONE) ? GAIN_ONE : vol_cfg);
    g = gain_track;
    if (g < tgt) begin
      if (step_cfg >= tgt - g) g = tgt;
      else g = g + step_cfg;
    end else if (g > tgt) begin
      if (step_cfg >= g - tgt) g = tgt;
      else g = g - step_cfg;
    end
    gain_track = g;
    r.left_out = scale_sample(f.left_in, g);
    r.right_out = scale_sample(f.right_in, g);
    r.gain_now = g;
    r.block_end_out = f.block_end;
    return r;
  endfunction

  function automatic int pick_pause(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 24);
  endfunction

  function automatic sgr_in_t mk_frame(input int l, input int r, input bit z, input bit b);
    sgr_in_t f;
    f.left_in = SAMPLE_W'(l);
    f.right_in = SAMPLE_W'(r);
    f.zero_gain = z;
    f.block_end = b;
    return f;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_GOAL_GAIN: vol_cfg = val;
      CFG_MUTE: mute_cfg = val[0];
      CFG_RAMP_STEP: step_cfg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [GAIN_W-1:0] vol, input bit m, input logic [GAIN_W-1:0] st);
    write_reg(CFG_GOAL_GAIN, vol);
    write_reg(CFG_MUTE, {(CFG_DATA_W-1)'($urandom), m});
    write_reg(CFG_RAMP_STEP, st);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pend_frames.size() != 0 || in_ch.valid || expected_frames.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) expected_frames.push_back(ramp_and_scale(in_ch.data));
      if (!in_ch.valid || in_ch.ready) begin
        if (idle_left != 0) begin
          idle_left--;
          in_ch.valid <= 1'b0;
        end else if (pend_frames.size() != 0) begin
          in_ch.data <= pend_frames.pop_front();
          in_ch.valid <= 1'b1;
          idle_left = pick_pause(calm_in);
          if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    sgr_out_t want;
    sgr_out_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_frames.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual %p", $time, got);
        end else begin
          want = expected_frames.pop_front();
          if (got.left_out !== want.left_out) begin
            errors++;
            $display("%0t: left_out expected %0d actual %0d", $time, want.left_out, got.left_out);
          end
          if (got.right_out !== want.right_out) begin
            errors++;
            $display("%0t: right_out expected %0d actual %0d", $time, want.right_out,
                     got.right_out);
          end
          if (got.gain_now !== want.gain_now) begin
            errors++;
            $display("%0t: gain_now expected %0d actual %0d", $time, want.gain_now, got.gain_now);
          end
          if (got.block_end_out !== want.block_end_out) begin
            errors++;
            $display("%0t: block_end_out expected %0b actual %0b", $time, want.block_end_out,
                     got.block_end_out);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_pause(calm_out);
        if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      end
    end
  end

  initial begin
    logic [GAIN_W-1:0] vol;
    logic [GAIN_W-1:0] st;
    sgr_in_t f;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_GOAL_GAIN;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults from reset
    pend_frames.push_back(mk_frame(-32768, 32767, 1'b1, 1'b0));
    pend_frames.push_back(mk_frame(32767, -32768, 1'b0, 1'b1));
    pend_frames.push_back(mk_frame(-1, 1, 1'b0, 1'b0));
    pend_frames.push_back(mk_frame(0, 0, 1'b0, 1'b1));
    wait_idle();

    // full scale with a step that lands on the target at once
    set_regs(GAIN_ONE, 1'b0, GAIN_ONE);
    pend_frames.push_back(mk_frame(-32768, 32767, 1'b0, 1'b0));
    pend_frames.push_back(mk_frame(-1, 1, 1'b0, 1'b1));
    pend_frames.push_back(mk_frame(12345, -12345, 1'b1, 1'b0));
    wait_idle();

    // target above one, zero step holds the gain
    set_regs({GAIN_W{1'b1}}, 1'b0, '0);
    pend_frames.push_back(mk_frame(-32768, 32767, 1'b0, 1'b0));
    pend_frames.push_back(mk_frame(-7, 7, 1'b0, 1'b1));
    wait_idle();

    // mute ramps down and clamps at zero
    set_regs({GAIN_W{1'b1}}, 1'b1, GAIN_W'(5000000));
    repeat (5) pend_frames.push_back(mk_frame(rand_sample(), rand_sample(), 1'b0, 1'b0));
    wait_idle();

    // zero step with clear
    set_regs(GAIN_ONE, 1'b0, '0);
    pend_frames.push_back(mk_frame(32767, -32768, 1'b1, 1'b0));
    pend_frames.push_back(mk_frame(-32768, 32767, 1'b0, 1'b1));
    wait_idle();

    repeat (10) begin
      case ($urandom_range(0, 5))
        0: vol = '0;
        1: vol = GAIN_ONE;
        2: vol = GAIN_W'($urandom_range(32'h1ffffff, 32'h1000001));
        default: vol = GAIN_W'($urandom_range(0, 32'h1000000));
      endcase
      case ($urandom_range(0, 11))
        0: st = '0;
        1, 2: st = GAIN_W'($urandom_range(1, 16));
        3: st = GAIN_W'($urandom_range(32'h1000000, 32'h1ffffff));
        default: st = GAIN_W'($urandom_range(1, 32'h100000));
      endcase
      set_regs(vol, $urandom_range(0, 3) == 0, st);
      repeat (75) begin
        f.left_in = rand_sample();
        f.right_in = rand_sample();
        f.zero_gain = ($urandom_range(0, 19) == 0);
        f.block_end = ($urandom_range(0, 7) == 0);
        pend_frames.push_back(f);
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("PASS stereo_gain_ramp");
    end else begin
      $display("FAIL stereo_gain_ramp");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAIL stereo_gain_ramp");
    $finish;
  end

endmodule

@@ stereo_gain_ramp.f @@
hw/rtl/sgr_pkg.sv
hw/rtl/sgr_stream_if.sv
hw/rtl/sgr_cfg.sv
hw/rtl/sgr_ramp.sv
hw/rtl/sgr_scale.sv
hw/rtl/stereo_gain_ramp.sv
tb/tb_top.sv
